// File: sv/dlbs_pkg.sv
// ----------------------------------------------------------------------------
// dlbs_pkg
// Shared types, codes and helpers of the distance level-of-detail sorter.
// ----------------------------------------------------------------------------
package dlbs_pkg;

	// Field widths
	localparam int POS_W    = 24;
	localparam int TAG_W    = 32;
	localparam int CMD_W    = 2;
	localparam int LEVEL_W  = 4;
	localparam int VALUE_W  = 11;
	localparam int CUT_W    = 24;
	localparam int NUM_CUT  = 8;
	localparam int SQ_W     = 2 * POS_W;
	localparam int D2_W     = SQ_W + 2;
	localparam int CFG_W    = 2 * CUT_W;
	localparam int CFG_IDX_W = 3;

	// Stream packing
	localparam int S_DATA_W = 3 * POS_W + TAG_W;
	localparam int M_BITS   = LEVEL_W + 2 * VALUE_W + 1 + TAG_W;
	localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [LEVEL_W-1:0] NOT_DRAWN = 4'd8;
	localparam logic [CUT_W-1:0]   CUT_INF   = 24'hFFFFFF;

	localparam logic KIND_COUNT = 1'b0;
	localparam logic KIND_PLACE = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_COUNT = 2'd0,
		CMD_CLOSE = 2'd1,
		CMD_PLACE = 2'd2,
		CMD_BEGIN = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EYE_X   = 3'd0,
		REG_EYE_Y   = 3'd1,
		REG_EYE_Z   = 3'd2,
		REG_LEVELS  = 3'd3,
		REG_CUT_01  = 3'd4,
		REG_CUT_23  = 3'd5,
		REG_CUT_45  = 3'd6,
		REG_CUT_67  = 3'd7
	} reg_idx_t;

	typedef enum logic {
		BK_IDLE,
		BK_CLOSE
	} bk_state_t;

	typedef struct packed {
		logic signed [POS_W-1:0]        eye_x;
		logic signed [POS_W-1:0]        eye_y;
		logic signed [POS_W-1:0]        eye_z;
		logic [LEVEL_W-1:0]             level_count;
		logic [NUM_CUT-1:0][CUT_W-1:0]  cutoff;
	} cfg_t;

	// Classified command handed from front to back
	typedef struct packed {
		cmd_t               cmd;
		logic [LEVEL_W-1:0] level;
		logic [TAG_W-1:0]   tag;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Number of levels in use, capped at the build limit
	function automatic logic [LEVEL_W-1:0] lv_in_use(input logic [LEVEL_W-1:0] lc,
		input logic [LEVEL_W-1:0] lim);
		return (lc > lim) ? lim : lc;
	endfunction

endpackage

// File: sv/dlbs_front.sv
// ----------------------------------------------------------------------------
// dlbs_front
// Accepts instances, computes squared eye distance and picks a detail level.
// ----------------------------------------------------------------------------
module dlbs_front import dlbs_pkg::*; #(
	parameter int MAX_LEVELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// pos_x, pos_y, pos_z, instance_tag
	input  logic [S_DATA_W-1:0]   s_axis_tdata,
	// cmd
	input  logic [CMD_W-1:0]      s_axis_tuser,
	output logic                  push,
	output q_entry_t              push_entry,
	input  q_stat_t               qs
);

	logic adv;
	logic v_s1, v_s2, v_s3;
	cmd_t cmd_s1, cmd_s2, cmd_s3;
	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3;
	logic signed [POS_W:0] dx_s1, dy_s1, dz_s1;
	logic signed [2*POS_W+1:0] px, py, pz;
	logic [SQ_W-1:0] sqx_s2, sqy_s2, sqz_s2;
	logic [SQ_W-1:0] csq_q [MAX_LEVELS];
	logic [D2_W-1:0] d2_s3;
	logic [LEVEL_W-1:0] n_lv;
	logic [LEVEL_W-1:0] lvl;

	// Advance the whole pipe unless the last stage is blocked by a full queue
	assign adv = !v_s3 || !qs.full;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: offsets from the eye
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd_t'(s_axis_tuser);
			tag_s1 <= s_axis_tdata[3*POS_W +: TAG_W];
			dx_s1  <= {s_axis_tdata[POS_W-1], s_axis_tdata[0 +: POS_W]}
				- {cfg.eye_x[POS_W-1], cfg.eye_x};
			dy_s1  <= {s_axis_tdata[2*POS_W-1], s_axis_tdata[POS_W +: POS_W]}
				- {cfg.eye_y[POS_W-1], cfg.eye_y};
			dz_s1  <= {s_axis_tdata[3*POS_W-1], s_axis_tdata[2*POS_W +: POS_W]}
				- {cfg.eye_z[POS_W-1], cfg.eye_z};
		end
	end

	assign px = (2*POS_W+2)'(dx_s1) * (2*POS_W+2)'(dx_s1);
	assign py = (2*POS_W+2)'(dy_s1) * (2*POS_W+2)'(dy_s1);
	assign pz = (2*POS_W+2)'(dz_s1) * (2*POS_W+2)'(dz_s1);

	// Stage 2: squares of the offsets and of the cutoffs
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2 <= cmd_s1;
			tag_s2 <= tag_s1;
			sqx_s2 <= px[SQ_W-1:0];
			sqy_s2 <= py[SQ_W-1:0];
			sqz_s2 <= pz[SQ_W-1:0];
			for (int l = 0; l < MAX_LEVELS; l++) begin
				csq_q[l] <= SQ_W'(cfg.cutoff[l]) * SQ_W'(cfg.cutoff[l]);
			end
		end
	end

	// Stage 3: squared distance
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s3 <= cmd_s2;
			tag_s3 <= tag_s2;
			d2_s3  <= {2'b00, sqx_s2} + {2'b00, sqy_s2} + {2'b00, sqz_s2};
		end
	end

	// Pick the first enabled level whose cutoff covers the distance
	always_comb begin
		n_lv = lv_in_use(cfg.level_count, LEVEL_W'(MAX_LEVELS));
		lvl  = NOT_DRAWN;
		for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
			if (LEVEL_W'(l) < n_lv && cfg.cutoff[l] != '0 &&
				(cfg.cutoff[l] == CUT_INF || d2_s3 <= {2'b00, csq_q[l]})) begin
				lvl = LEVEL_W'(l);
			end
		end
	end

	assign push       = v_s3 && !qs.full;
	assign push_entry = '{cmd: cmd_s3, level: lvl, tag: tag_s3};

endmodule

// File: sv/dlbs_queue.sv
// ----------------------------------------------------------------------------
// dlbs_queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module dlbs_queue import dlbs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	input  logic     pop,
	output q_entry_t head,
	output q_stat_t  qs
);

	localparam int QA_W = $clog2(QUEUE_DEPTH);

	q_entry_t mem_q [QUEUE_DEPTH];
	logic [QA_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QA_W:0]   cnt_q;

	assign qs.full  = (cnt_q == (QA_W+1)'(QUEUE_DEPTH));
	assign qs.empty = (cnt_q == '0);
	assign head     = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

// File: sv/dlbs_back.sv
// ----------------------------------------------------------------------------
// dlbs_back
// Carries out queued commands on the level counts and cursors and drives
// the result stream through an output register.
// ----------------------------------------------------------------------------
module dlbs_back import dlbs_pkg::*; #(
	parameter int MAX_LEVELS    = 8,
	parameter int MAX_INSTANCES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [LEVEL_W-1:0]  level_count,
	input  q_entry_t            head,
	input  q_stat_t             qs,
	output logic                pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// level, value, offset, drawn, tag_out, zero fill
	output logic [M_DATA_W-1:0] m_axis_tdata,
	// kind
	output logic [0:0]          m_axis_tuser,
	// last
	output logic                m_axis_tlast
);

	localparam int CW  = $clog2(MAX_INSTANCES + 1);
	localparam int LIW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam logic [CW:0] MAXV = (CW+1)'(MAX_INSTANCES);

	bk_state_t state_q, state_d;
	logic [CW-1:0]  counts_q  [MAX_LEVELS];
	logic [CW-1:0]  cursors_q [MAX_LEVELS];
	logic [LIW-1:0] step_q;
	logic [CW-1:0]  at_q;

	logic [LEVEL_W-1:0] n_lv;
	logic [LIW-1:0]     sel;
	logic [CW-1:0]      cnt_sel, cur_sel;
	logic [CW:0]        at_sum;
	logic [CW-1:0]      at_next;
	logic [CW-1:0]      cnt_inc, cur_inc;
	logic               drawn_h, out_free, step_last;

	// Control decoded per cycle
	logic clr_all, clr_cur, inc_cnt, inc_cur, ld_cur, step_adv, close_start;
	logic emit_place, emit_report;

	// Output register
	logic               o_valid_q;
	logic               o_kind_q;
	logic [LEVEL_W-1:0] o_level_q;
	logic [VALUE_W-1:0] o_value_q, o_offset_q;
	logic               o_drawn_q;
	logic [TAG_W-1:0]   o_tag_q;
	logic               o_last_q;

	logic [CW+VALUE_W-1:0] cnt_ext, cur_ext, at_ext;

	assign n_lv      = lv_in_use(level_count, LEVEL_W'(MAX_LEVELS));
	assign drawn_h   = (head.level != NOT_DRAWN);
	assign out_free  = !o_valid_q || m_axis_tready;
	assign sel       = (state_q == BK_CLOSE) ? step_q : head.level[LIW-1:0];
	assign cnt_sel   = counts_q[sel];
	assign cur_sel   = cursors_q[sel];
	assign step_last = (LEVEL_W'(step_q) + 1'b1 == n_lv);

	// Saturating updates
	assign cnt_inc = (cnt_sel == MAXV[CW-1:0]) ? cnt_sel : cnt_sel + 1'b1;
	assign cur_inc = (cur_sel == MAXV[CW-1:0]) ? cur_sel : cur_sel + 1'b1;
	assign at_sum  = {1'b0, at_q} + {1'b0, cnt_sel};
	assign at_next = (at_sum > MAXV) ? MAXV[CW-1:0] : at_sum[CW-1:0];

	// Mask counts to the value field width
	assign cnt_ext = {{VALUE_W{1'b0}}, cnt_sel};
	assign cur_ext = {{VALUE_W{1'b0}}, cur_sel};
	assign at_ext  = {{VALUE_W{1'b0}}, at_q};

	// Next state and command decode
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		clr_all     = 1'b0;
		clr_cur     = 1'b0;
		inc_cnt     = 1'b0;
		inc_cur     = 1'b0;
		ld_cur      = 1'b0;
		step_adv    = 1'b0;
		close_start = 1'b0;
		emit_place  = 1'b0;
		emit_report = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!qs.empty) begin
					unique case (head.cmd)
						CMD_BEGIN: begin
							clr_all = 1'b1;
							pop     = 1'b1;
						end
						CMD_COUNT: begin
							inc_cnt = drawn_h;
							pop     = 1'b1;
						end
						CMD_PLACE: begin
							if (out_free) begin
								emit_place = 1'b1;
								inc_cur    = drawn_h;
								pop        = 1'b1;
							end
						end
						CMD_CLOSE: begin
							if (n_lv == '0) begin
								clr_cur = 1'b1;
								pop     = 1'b1;
							end else begin
								close_start = 1'b1;
								state_d     = BK_CLOSE;
							end
						end
						default: ;
					endcase
				end
			end
			BK_CLOSE: begin
				if (out_free) begin
					emit_report = 1'b1;
					ld_cur      = 1'b1;
					clr_cur     = (step_q == '0);
					step_adv    = 1'b1;
					if (step_last) begin
						pop     = 1'b1;
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Update counts, cursors and the close walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				counts_q[i]  <= '0;
				cursors_q[i] <= '0;
			end
			step_q <= '0;
			at_q   <= '0;
		end else begin
			if (clr_all) begin
				for (int i = 0; i < MAX_LEVELS; i++) counts_q[i] <= '0;
			end else if (inc_cnt) begin
				counts_q[sel] <= cnt_inc;
			end
			for (int i = 0; i < MAX_LEVELS; i++) begin
				if (ld_cur && LIW'(i) == sel) begin
					cursors_q[i] <= at_q;
				end else if (inc_cur && LIW'(i) == sel) begin
					cursors_q[i] <= cur_inc;
				end else if (clr_all || clr_cur) begin
					cursors_q[i] <= '0;
				end
			end
			if (close_start) begin
				step_q <= '0;
				at_q   <= '0;
			end else if (step_adv) begin
				step_q <= step_q + 1'b1;
				at_q   <= at_next;
			end
		end
	end

	// Hold or drop the output transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (emit_place || emit_report) begin
			o_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_place) begin
			o_kind_q   <= KIND_PLACE;
			o_level_q  <= head.level;
			o_value_q  <= drawn_h ? cur_ext[VALUE_W-1:0] : '0;
			o_offset_q <= '0;
			o_drawn_q  <= drawn_h;
			o_tag_q    <= head.tag;
			o_last_q   <= 1'b1;
		end else if (emit_report) begin
			o_kind_q   <= KIND_COUNT;
			o_level_q  <= LEVEL_W'(step_q);
			o_value_q  <= cnt_ext[VALUE_W-1:0];
			o_offset_q <= at_ext[VALUE_W-1:0];
			o_drawn_q  <= 1'b0;
			o_tag_q    <= '0;
			o_last_q   <= step_last;
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tuser  = o_kind_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = M_DATA_W'({o_tag_q, o_drawn_q, o_offset_q, o_value_q, o_level_q});

`ifndef SYNTHESIS
	a_close_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_CLOSE |-> !qs.empty)
		else $error("close walk running with an empty queue");

	a_place_last: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && o_kind_q == KIND_PLACE) |-> o_last_q)
		else $error("placement result without last");

	a_not_drawn: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && o_kind_q == KIND_PLACE && !o_drawn_q)
		|-> (o_level_q == NOT_DRAWN && o_value_q == '0))
		else $error("not-drawn placement carries a level or slot");

	a_report_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && o_kind_q == KIND_COUNT && !o_last_q && m_axis_tready)
		|=> (o_valid_q && o_kind_q == KIND_COUNT))
		else $error("count report burst broken");
`endif

endmodule

// File: sv/distance_lod_bucket_sort.sv
// Path: a place item passes stages two and three, the queue write and the back-end
//   update before it reaches the output register; count items update counts only.
// Throughput: one begin, count or place item per cycle unless the output or queue
//   stalls; a close is paced by the back-end report walk, one report per level in use.
// Reset: asynchronous; clears counts, cursors, queue, pipeline valids and the
//   configuration registers (eye at origin, one level, all cutoffs disabled).
// ----------------------------------------------------------------------------
// distance_lod_bucket_sort
// Distance-based detail-level selection with a counting sort of instances
// into contiguous level-ordered runs.
// ----------------------------------------------------------------------------
module distance_lod_bucket_sort import dlbs_pkg::*; #(
	parameter int MAX_LEVELS    = 8,
	parameter int MAX_INSTANCES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// pos_x, pos_y, pos_z, instance_tag
	input  logic [S_DATA_W-1:0]   s_axis_tdata,
	// cmd
	input  logic [CMD_W-1:0]      s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// level, value, offset, drawn, tag_out, zero fill
	output logic [M_DATA_W-1:0]   m_axis_tdata,
	// kind
	output logic [0:0]            m_axis_tuser,
	// last
	output logic                  m_axis_tlast
);

	cfg_t     cfg_q;
	logic     push, pop;
	q_entry_t push_entry, head;
	q_stat_t  qs;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{eye_x: '0, eye_y: '0, eye_z: '0, level_count: LEVEL_W'(1),
				cutoff: '0};
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_EYE_X:  cfg_q.eye_x <= cfg_data[POS_W-1:0];
				REG_EYE_Y:  cfg_q.eye_y <= cfg_data[POS_W-1:0];
				REG_EYE_Z:  cfg_q.eye_z <= cfg_data[POS_W-1:0];
				REG_LEVELS: cfg_q.level_count <= cfg_data[LEVEL_W-1:0];
				REG_CUT_01: cfg_q.cutoff[1:0] <= cfg_data;
				REG_CUT_23: cfg_q.cutoff[3:2] <= cfg_data;
				REG_CUT_45: cfg_q.cutoff[5:4] <= cfg_data;
				REG_CUT_67: cfg_q.cutoff[7:6] <= cfg_data;
				default: ;
			endcase
		end
	end

	dlbs_front #(
		.MAX_LEVELS(MAX_LEVELS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push          (push),
		.push_entry    (push_entry),
		.qs            (qs)
	);

	dlbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qs         (qs)
	);

	dlbs_back #(
		.MAX_LEVELS    (MAX_LEVELS),
		.MAX_INSTANCES (MAX_INSTANCES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.level_count   (cfg_q.level_count),
		.head          (head),
		.qs            (qs),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
